[design/ptc_pkg.sv]
// Shared constants and types for the page table translate/check block.
// No dependencies; imported by every other design file.
package ptc_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int NUM_PAGES_DEF  = 256;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int PERM_W   = 3;
  localparam int RIGHTS_W = 4;
  localparam int PADDR_W  = 20;
  localparam int FAULT_W  = 3;

  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNMAP     = 2'd2;

  localparam logic [FAULT_W-1:0] FAULT_OK       = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_VIRT_OOR = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_PHYS_OOR = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_UNMAPPED = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_NO_READ  = 3'd4;
  localparam logic [FAULT_W-1:0] FAULT_NO_WRITE = 3'd5;
  localparam logic [FAULT_W-1:0] FAULT_NO_EXEC  = 3'd6;
  localparam logic [FAULT_W-1:0] FAULT_UNUSED   = 3'd7;

  // bit positions in the stored rights field
  localparam int RIGHT_READ    = 0;
  localparam int RIGHT_WRITE   = 1;
  localparam int RIGHT_EXEC    = 2;
  localparam int RIGHT_PRESENT = 3;

  // table port strobes from the controller
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

[design/ptc_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on ptc_pkg for field widths.
interface ptc_req_if import ptc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ADDR_W-1:0]   virt_addr;
  logic [ADDR_W-1:0]   virt_page;
  logic [ADDR_W-1:0]   phys_page;
  logic [PERM_W-1:0]   perm_bits;

  modport source (output valid, command, virt_addr, virt_page, phys_page, perm_bits,
                  input ready);
  modport sink   (input valid, command, virt_addr, virt_page, phys_page, perm_bits,
                  output ready);
  modport mon    (input valid, ready, command, virt_addr, virt_page, phys_page,
                  perm_bits);
endinterface

interface ptc_rsp_if import ptc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [PADDR_W-1:0]  phys_addr;
  logic [FAULT_W-1:0]  fault;

  modport source (output valid, phys_addr, fault, input ready);
  modport sink   (input valid, phys_addr, fault, output ready);
  modport mon    (input valid, ready, phys_addr, fault);
endinterface

[design/page_table_translate_check.sv]
// Top level of the single-level page table MMU.
// Depends on ptc_pkg, ptc_if, ptc_table and ptc_ctrl.
//
// Usage:
//   req : translate / map / unmap requests, valid/ready.
//   rsp : one response per request (phys_addr, fault), valid/ready.
// Each request reads its page table entry from a synchronous RAM with a
// registered read, checks it, writes back on map/unmap and loads the
// response register. A new request is not taken until the RAM read and
// the check/write-back on the current entry are done; the check/write-back
// waits while a held response is stalled.
// After reset the table is swept to unmapped, one entry per cycle;
// req.ready stays low until the sweep is done.
// A stalled response holds in its register; the block still takes the
// next request, and finishes it as soon as the held response is taken.
// PAGE_BYTES must be a power of two; physical addresses wrap at 2^20.
module page_table_translate_check import ptc_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ptc_req_if.sink   req,
  ptc_rsp_if.source rsp
);

  localparam int IW = $clog2(NUM_PAGES);

  tbl_ctl_t             tbl_ctl;
  logic                 clearing;
  logic [IW-1:0]        rd_idx;
  logic [IW-1:0]        wr_idx;
  logic [IW-1:0]        wr_frame;
  logic [RIGHTS_W-1:0]  wr_rights;
  logic [IW-1:0]        rd_frame;
  logic [RIGHTS_W-1:0]  rd_rights;

  ptc_ctrl #(
    .PAGE_BYTES (PAGE_BYTES),
    .NUM_PAGES  (NUM_PAGES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .clearing  (clearing),
    .tbl_ctl   (tbl_ctl),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx),
    .wr_frame  (wr_frame),
    .wr_rights (wr_rights),
    .rd_frame  (rd_frame),
    .rd_rights (rd_rights)
  );

  ptc_table #(
    .NUM_PAGES (NUM_PAGES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tbl_ctl),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx),
    .wr_frame  (wr_frame),
    .wr_rights (wr_rights),
    .rd_frame  (rd_frame),
    .rd_rights (rd_rights),
    .clearing  (clearing)
  );

endmodule

[design/ptc_table.sv]
// Page table storage: one synchronous RAM, registered read, one write port,
// plus the clearing sweep that runs after reset. Depends on ptc_pkg.
module ptc_table import ptc_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tbl_ctl_t                     ctl,
  input  logic [$clog2(NUM_PAGES)-1:0] rd_idx,
  input  logic [$clog2(NUM_PAGES)-1:0] wr_idx,
  input  logic [$clog2(NUM_PAGES)-1:0] wr_frame,
  input  logic [RIGHTS_W-1:0]          wr_rights,
  output logic [$clog2(NUM_PAGES)-1:0] rd_frame,
  output logic [RIGHTS_W-1:0]          rd_rights,
  output logic                         clearing
);

  localparam int IW = $clog2(NUM_PAGES);
  localparam int EW = IW + RIGHTS_W;

  logic [EW-1:0] mem [NUM_PAGES];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IW'(NUM_PAGES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_idx] <= {wr_frame, wr_rights};
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  assign rd_frame  = rd_data[EW-1:RIGHTS_W];
  assign rd_rights = rd_data[RIGHTS_W-1:0];

endmodule

[design/ptc_ctrl.sv]
// Request sequencer: bounds checks, table read, rights check, write-back
// and the response register. Depends on ptc_pkg and ptc_if.
module ptc_ctrl import ptc_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  ptc_req_if.sink                      req,
  ptc_rsp_if.source                    rsp,
  input  logic                         clearing,
  output tbl_ctl_t                     tbl_ctl,
  output logic [$clog2(NUM_PAGES)-1:0] rd_idx,
  output logic [$clog2(NUM_PAGES)-1:0] wr_idx,
  output logic [$clog2(NUM_PAGES)-1:0] wr_frame,
  output logic [RIGHTS_W-1:0]          wr_rights,
  input  logic [$clog2(NUM_PAGES)-1:0] rd_frame,
  input  logic [RIGHTS_W-1:0]          rd_rights
);

  localparam int IW = $clog2(NUM_PAGES);
  localparam int OB = $clog2(PAGE_BYTES);

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t             state;
  logic               accept;
  logic [ADDR_W-1:0]  vpn_in;
  logic [ADDR_W-1:0]  idx_in;

  // captured request
  logic [CMD_W-1:0]   cmd;
  logic [IW-1:0]      vidx;
  logic [IW-1:0]      pidx;
  logic [OB-1:0]      offset;
  logic [PERM_W-1:0]  perms;
  logic               virt_ok;
  logic               phys_ok;

  logic               out_free;
  logic [FAULT_W-1:0] fault_next;
  logic [PADDR_W-1:0] addr_next;
  logic               wr_next;
  logic [PADDR_W+IW+OB-1:0] addr_full;

  logic               rsp_valid;
  logic [PADDR_W-1:0] rsp_addr;
  logic [FAULT_W-1:0] rsp_fault;

  assign req.ready = (state == S_IDLE) && !clearing;
  assign accept    = req.valid && req.ready;
  assign vpn_in    = req.virt_addr >> OB;
  assign idx_in    = (req.command == CMD_TRANSLATE) ? vpn_in : req.virt_page;
  assign rd_idx    = idx_in[IW-1:0];
  assign out_free  = !rsp_valid || rsp.ready;

  assign addr_full = {{PADDR_W{1'b0}}, rd_frame, offset};

  always_comb begin
    fault_next = FAULT_OK;
    addr_next  = '0;
    wr_next    = 1'b0;
    wr_frame   = pidx;
    wr_rights  = {1'b1, perms};
    case (cmd)
      CMD_TRANSLATE: begin
        if (!virt_ok) begin
          fault_next = FAULT_VIRT_OOR;
        end else if (!rd_rights[RIGHT_PRESENT]) begin
          fault_next = FAULT_UNMAPPED;
        end else if (perms[RIGHT_READ] && !rd_rights[RIGHT_READ]) begin
          fault_next = FAULT_NO_READ;
        end else if (perms[RIGHT_WRITE] && !rd_rights[RIGHT_WRITE]) begin
          fault_next = FAULT_NO_WRITE;
        end else if (perms[RIGHT_EXEC] && !rd_rights[RIGHT_EXEC]) begin
          fault_next = FAULT_NO_EXEC;
        end else begin
          addr_next = addr_full[PADDR_W-1:0];
        end
      end
      CMD_MAP: begin
        if (!virt_ok) begin
          fault_next = FAULT_VIRT_OOR;
        end else if (!phys_ok) begin
          fault_next = FAULT_PHYS_OOR;
        end else begin
          wr_next = 1'b1;
        end
      end
      CMD_UNMAP: begin
        // rights cleared, stored frame kept
        wr_frame  = rd_frame;
        wr_rights = '0;
        if (!virt_ok) begin
          fault_next = FAULT_VIRT_OOR;
        end else begin
          wr_next = 1'b1;
        end
      end
      default: begin
        fault_next = FAULT_OK;
      end
    endcase
  end

  assign wr_idx        = vidx;
  assign tbl_ctl.rd_en = accept;
  assign tbl_ctl.wr_en = (state == S_LOOK) && out_free && wr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
          end
          if (accept) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= req.command;
      vidx    <= idx_in[IW-1:0];
      pidx    <= req.phys_page[IW-1:0];
      offset  <= req.virt_addr[OB-1:0];
      perms   <= req.perm_bits;
      virt_ok <= idx_in < ADDR_W'(NUM_PAGES);
      phys_ok <= req.phys_page < ADDR_W'(NUM_PAGES);
    end
    if (state == S_LOOK && out_free) begin
      rsp_addr  <= addr_next;
      rsp_fault <= fault_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.phys_addr = rsp_addr;
  assign rsp.fault     = rsp_fault;

endmodule

[design/ptc_check.sv]
// Port-level assertions for page_table_translate_check, bound to the top.
// Depends on ptc_pkg and ptc_if.
module ptc_check import ptc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [PADDR_W-1:0] rsp_phys_addr,
  input logic [FAULT_W-1:0] rsp_fault
);

  // table sweep keeps requests out right after reset
  a_reset_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready right after reset");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted back to back");

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_fault != FAULT_OK) |-> rsp_phys_addr == '0)
    else $error("faulting response carries an address");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_fault != FAULT_UNUSED)
    else $error("undefined fault code");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_fault) && $stable(rsp_phys_addr)))
    else $error("stalled response changed");

endmodule

bind page_table_translate_check ptc_check u_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_phys_addr (rsp.phys_addr),
  .rsp_fault     (rsp.fault)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for page_table_translate_check: directed and random map/unmap/translate
// requests, predicted by a scoreboard class that tracks its own page table.
// Depends on ptc_pkg, ptc_if and the design top level.
module tb;
  import ptc_pkg::*;

  localparam int PAGE_BYTES   = PAGE_BYTES_DEF;
  localparam int NUM_PAGES    = NUM_PAGES_DEF;
  localparam int RANDOM_COUNT = 1525;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRESSURE_AT  = 400;

  // command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] virt_page;
    logic [ADDR_W-1:0] phys_page;
    logic [PERM_W-1:0] perm_bits;
  } req_item_t;

  typedef struct packed {
    logic [PADDR_W-1:0] phys_addr;
    logic [FAULT_W-1:0] fault;
  } rsp_item_t;

  class page_table_scoreboard;
    logic [ADDR_W-1:0]   frame_of [NUM_PAGES];
    logic [RIGHTS_W-1:0] rights_of[NUM_PAGES];
    rsp_item_t           pending_rsp[$];
    int unsigned         errors;

    function new();
      foreach (frame_of[i]) begin
        frame_of[i]  = '0;
        rights_of[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction

    // work out the response and update the table as the block should
    function void note_request(req_item_t r);
      rsp_item_t           rsp;
      logic [ADDR_W-1:0]   vp;
      logic [ADDR_W-1:0]   off;
      logic [RIGHTS_W-1:0] have;
      longint unsigned     full;
      rsp = '0;
      case (r.command)
        CMD_TRANSLATE: begin
          vp  = r.virt_addr / PAGE_BYTES;
          off = r.virt_addr % PAGE_BYTES;
          if (vp >= NUM_PAGES) begin
            rsp.fault = FAULT_VIRT_OOR;
          end else begin
            have = rights_of[vp];
            if (!have[RIGHT_PRESENT])
              rsp.fault = FAULT_UNMAPPED;
            else if (r.perm_bits[RIGHT_READ] && !have[RIGHT_READ])
              rsp.fault = FAULT_NO_READ;
            else if (r.perm_bits[RIGHT_WRITE] && !have[RIGHT_WRITE])
              rsp.fault = FAULT_NO_WRITE;
            else if (r.perm_bits[RIGHT_EXEC] && !have[RIGHT_EXEC])
              rsp.fault = FAULT_NO_EXEC;
            else begin
              full = longint'(frame_of[vp]) * PAGE_BYTES + off;
              rsp.phys_addr = full[PADDR_W-1:0];
            end
          end
        end
        CMD_MAP: begin
          if (r.virt_page >= NUM_PAGES)
            rsp.fault = FAULT_VIRT_OOR;
          else if (r.phys_page >= NUM_PAGES)
            rsp.fault = FAULT_PHYS_OOR;
          else begin
            frame_of[r.virt_page]  = r.phys_page;
            rights_of[r.virt_page] = {1'b1, r.perm_bits};
          end
        end
        CMD_UNMAP: begin
          if (r.virt_page >= NUM_PAGES)
            rsp.fault = FAULT_VIRT_OOR;
          else
            rights_of[r.virt_page] = '0;  // frame is kept
        end
        default: ;
      endcase
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: phys_addr %0h fault %0d", got.phys_addr, got.fault);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.phys_addr !== want.phys_addr) begin
        $error("phys_addr mismatch: expected %0h, actual %0h", want.phys_addr, got.phys_addr);
        errors++;
      end
      if (got.fault !== want.fault) begin
        $error("fault mismatch: expected %0d, actual %0d", want.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ptc_req_if req_ch();
  ptc_rsp_if rsp_ch();

  page_table_translate_check #(
    .PAGE_BYTES(PAGE_BYTES),
    .NUM_PAGES (NUM_PAGES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  page_table_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned sent_count  = 0;
  int unsigned rsp_count   = 0;
  bit          hold_off_req = 0;
  bit          holding      = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response('{phys_addr: rsp_ch.phys_addr, fault: rsp_ch.fault});
        rsp_count++;
      end
      if (req_ch.valid && req_ch.ready)
        sb.note_request('{command: req_ch.command, virt_addr: req_ch.virt_addr,
                          virt_page: req_ch.virt_page, phys_page: req_ch.phys_page,
                          perm_bits: req_ch.perm_bits});
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(input req_item_t r);
    int gap;
    // bursts with no gaps, and none while the receiver holds off
    if (holding || (sent_count % 128) < 32)
      gap = 0;
    else
      gap = $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= r.command;
    req_ch.virt_addr <= r.virt_addr;
    req_ch.virt_page <= r.virt_page;
    req_ch.phys_page <= r.phys_page;
    req_ch.perm_bits <= r.perm_bits;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] va,
                             input logic [ADDR_W-1:0] vp, input logic [ADDR_W-1:0] pp,
                             input logic [PERM_W-1:0] perms);
    send_request('{command: cmd, virt_addr: va, virt_page: vp, phys_page: pp,
                   perm_bits: perms});
  endtask

  function automatic logic [ADDR_W-1:0] page_addr(int unsigned page, int unsigned off);
    return ADDR_W'(page * PAGE_BYTES + off);
  endfunction

  function automatic req_item_t random_request();
    req_item_t         r;
    int                sel;
    logic [ADDR_W-1:0] vp;
    r.virt_addr = $urandom;
    r.virt_page = $urandom;
    r.phys_page = $urandom;
    r.perm_bits = PERM_W'($urandom_range(0, 7));
    // a hot set of low pages so translates mostly hit mapped entries
    vp  = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, NUM_PAGES - 1);
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      r.command = CMD_TRANSLATE;
      if ($urandom_range(0, 9) != 0)
        r.virt_addr = page_addr(vp, $urandom_range(0, PAGE_BYTES - 1));
    end else if (sel < 80) begin
      r.command = CMD_MAP;
      if ($urandom_range(0, 9) != 0) r.virt_page = vp;
      if ($urandom_range(0, 9) != 0) r.phys_page = $urandom_range(0, NUM_PAGES - 1);
    end else if (sel < 96) begin
      r.command = CMD_UNMAP;
      if ($urandom_range(0, 9) != 0) r.virt_page = vp;
    end else begin
      r.command = CMD_NONE;
    end
    return r;
  endfunction

  // response side
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        holding      = 1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 0;
      end
      gap = ((rsp_count / 64) % 4 == 1) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.command   <= CMD_TRANSLATE;
    req_ch.virt_addr <= '0;
    req_ch.virt_page <= '0;
    req_ch.phys_page <= '0;
    req_ch.perm_bits <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // fresh table, bounds and check order
    send_fields(CMD_TRANSLATE, '0, '0, '0, 3'd0);
    send_fields(CMD_TRANSLATE, ALL_ONES, '0, '0, 3'd7);
    send_fields(CMD_TRANSLATE, page_addr(NUM_PAGES, 0), '0, '0, 3'd0);
    send_fields(CMD_MAP, '0, ALL_ONES, ALL_ONES, 3'd7);
    send_fields(CMD_MAP, '0, NUM_PAGES, '0, 3'd7);
    send_fields(CMD_MAP, '0, NUM_PAGES - 1, NUM_PAGES, 3'd7);
    send_fields(CMD_MAP, '0, '0, ALL_ONES, 3'd7);
    send_fields(CMD_MAP, ALL_ONES, '0, NUM_PAGES - 1, 3'd7);
    send_fields(CMD_MAP, ALL_ONES, NUM_PAGES - 1, '0, 3'd0);
    send_fields(CMD_TRANSLATE, page_addr(0, PAGE_BYTES - 1), ALL_ONES, ALL_ONES, 3'd7);
    send_fields(CMD_TRANSLATE, page_addr(NUM_PAGES - 1, PAGE_BYTES - 1), '0, '0, 3'd0);
    send_fields(CMD_TRANSLATE, page_addr(NUM_PAGES - 1, 0), '0, '0, 3'd1);
    send_fields(CMD_TRANSLATE, page_addr(NUM_PAGES - 1, 0), '0, '0, 3'd2);
    send_fields(CMD_TRANSLATE, page_addr(NUM_PAGES - 1, 0), '0, '0, 3'd4);
    // read-only page: write fault wins over exec fault
    send_fields(CMD_MAP, '0, 1, NUM_PAGES / 2, 3'd1);
    send_fields(CMD_TRANSLATE, page_addr(1, 5), '0, '0, 3'd7);
    send_fields(CMD_MAP, '0, 2, 3, 3'd3);
    send_fields(CMD_TRANSLATE, page_addr(2, 9), '0, '0, 3'd5);
    // failed map must not touch the entry
    send_fields(CMD_MAP, '0, 2, NUM_PAGES, 3'd0);
    send_fields(CMD_TRANSLATE, page_addr(2, 9), '0, '0, 3'd3);
    send_fields(CMD_UNMAP, '0, '0, '0, 3'd0);
    send_fields(CMD_TRANSLATE, page_addr(0, 1), '0, '0, 3'd0);
    send_fields(CMD_UNMAP, '0, ALL_ONES, '0, 3'd0);
    send_fields(CMD_UNMAP, '0, NUM_PAGES, '0, 3'd0);
    send_fields(CMD_NONE, ALL_ONES, ALL_ONES, ALL_ONES, 3'd7);
    send_fields(CMD_MAP, '0, '0, 5, 3'd6);
    send_fields(CMD_TRANSLATE, page_addr(0, PAGE_BYTES / 2), '0, '0, 3'd6);

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == PRESSURE_AT) hold_off_req = 1;
      send_request(random_request());
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // every accepted request must have been answered
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
